>>> src/hfc_pkg.sv
// Shared constants, codes and control types for the handshake frame capture block
package hfc_pkg;

	localparam int SLOT_BYTES  = 256;
	localparam int NUM_SLOTS   = 6;
	localparam int NUM_BUFS    = 7;
	localparam int STORE_DEPTH = NUM_BUFS * SLOT_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [2:0] NO_SLOT = 3'd6;
	localparam logic [8:0] POS_MAX = 9'd511;

	localparam logic [1:0] FN_BYTE  = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	localparam logic [1:0] KIND_MGMT = 2'd0;
	localparam logic [1:0] KIND_CTRL = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_MISC = 2'd3;

	localparam logic [1:0] RK_FRAME = 2'd0;
	localparam logic [1:0] RK_READ  = 2'd1;
	localparam logic [1:0] RK_CLEAR = 2'd2;

	localparam logic [1:0] VD_CAPTURED = 2'd0;
	localparam logic [1:0] VD_OTHER    = 2'd1;
	localparam logic [1:0] VD_LONG     = 2'd2;
	localparam logic [1:0] VD_REJECT   = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_frame;
		logic load_clear;
		logic load_read;
	} cmd_t;

	typedef struct packed {
		logic is_byte;
		logic is_last;
		logic is_read;
		logic is_clear;
	} sts_t;

endpackage

>>> src/hfc_ctrl.sv
// Controller: input acceptance, read sequencing and output register occupancy
module hfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	output logic          result_valid,
	input  logic          result_stall,
	input  hfc_pkg::sts_t sts,
	output hfc_pkg::cmd_t cmd
);
	import hfc_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   valid_q;
	logic   valid_next;
	logic   out_free;
	logic   accept;

	assign out_free = !valid_q || !result_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.is_read)
					state_next = ST_READ;
			end
			ST_READ: state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall     = 1'b1;
		cmd.load_read  = 1'b0;
		case (state_q)
			ST_IDLE: item_stall = !out_free;
			ST_READ: begin
				item_stall    = 1'b1;
				cmd.load_read = 1'b1;
			end
			default: item_stall = 1'b1;
		endcase
		accept         = item_valid && !item_stall;
		cmd.accept     = accept;
		cmd.load_frame = accept && sts.is_byte && sts.is_last;
		cmd.load_clear = accept && sts.is_clear;
	end

	always_comb begin
		valid_next = valid_q;
		if (!result_stall)
			valid_next = 1'b0;
		if (cmd.load_frame || cmd.load_clear || cmd.load_read)
			valid_next = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			valid_q <= valid_next;
		end
	end

	assign result_valid = valid_q;

endmodule

>>> src/hfc_datapath.sv
// Datapath: frame store, slot table, header latches, classification and result register
module hfc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  hfc_pkg::cmd_t cmd,
	output hfc_pkg::sts_t sts,
	input  logic [1:0]    func,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic [1:0]    frame_kind,
	input  logic [2:0]    read_slot,
	input  logic [7:0]    read_offset,
	output logic [1:0]    result_kind,
	output logic [1:0]    verdict,
	output logic [2:0]    slot_index,
	output logic [2:0]    captured_count,
	output logic          all_captured,
	output logic [7:0]    read_data,
	output logic [7:0]    read_length
);
	import hfc_pkg::*;

	localparam logic [8:0] POS_B0  = 9'h000;
	localparam logic [8:0] POS_B1  = 9'h001;
	localparam logic [8:0] POS_SQL = 9'h016;
	localparam logic [8:0] POS_SQH = 9'h017;
	localparam logic [8:0] POS_ETH = 9'h020;
	localparam logic [8:0] POS_ETL = 9'h021;
	localparam logic [8:0] MIN_KEY_LEN = 9'h022;
	localparam logic [7:0] ETH_HI  = 8'h88;
	localparam logic [7:0] ETH_LO  = 8'h8e;

	logic [7:0]        store_q [STORE_DEPTH];
	logic [7:0]        rdata_q;
	logic [2:0]        map_q [NUM_SLOTS];
	logic [2:0]        spare_q;
	logic [7:0]        len_q [NUM_SLOTS];
	logic [2:0]        cnt_q;
	logic [8:0]        pos_q;
	logic [7:0]        hdr_q [6];
	logic [7:0]        rd_len_s1;
	logic              rd_ok_s1;

	logic [7:0]        hdr_w [6];
	logic [8:0]        pos_inc;
	logic              wr_en;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [2:0]        cls;
	logic [1:0]        vd;
	logic              capture;
	logic [2:0]        cnt_next;
	logic [2:0]        rs_ix;
	logic              rs_ok;
	logic [7:0]        rs_len;
	logic              rd_ok;
	logic              do_byte;
	logic              do_read;

	assign sts.is_byte  = func == FN_BYTE;
	assign sts.is_last  = last_byte;
	assign sts.is_read  = func == FN_READ;
	assign sts.is_clear = func == FN_CLEAR;

	assign do_byte = cmd.accept && sts.is_byte;
	assign do_read = cmd.accept && sts.is_read;

	always_comb begin
		for (int i = 0; i < 6; i++)
			hdr_w[i] = hdr_q[i];
		case (pos_q)
			POS_B0:  hdr_w[0] = data_byte;
			POS_B1:  hdr_w[1] = data_byte;
			POS_SQL: hdr_w[2] = data_byte;
			POS_SQH: hdr_w[3] = data_byte;
			POS_ETH: hdr_w[4] = data_byte;
			POS_ETL: hdr_w[5] = data_byte;
			default: ;
		endcase
	end

	assign pos_inc = (pos_q == POS_MAX) ? POS_MAX : pos_q + 9'd1;
	assign wr_en   = do_byte && (32'(pos_q) < SLOT_BYTES);
	assign waddr   = ADDR_W'(spare_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_q);

	always_comb begin
		logic seq0;
		logic seq1;
		logic to_ds;
		logic from_ds;
		seq0    = (hdr_w[2][7:4] == 4'd0) && (hdr_w[3] == 8'd0);
		seq1    = (hdr_w[2][7:4] == 4'd1) && (hdr_w[3] == 8'd0);
		to_ds   = hdr_w[1][0];
		from_ds = hdr_w[1][1];
		cls     = NO_SLOT;
		if (hdr_w[0][3:2] == 2'd0 && hdr_w[0][7:4] == 4'd0)
			cls = 3'd0;
		else if (hdr_w[0][3:2] == 2'd0 && hdr_w[0][7:4] == 4'd1)
			cls = 3'd1;
		else if (pos_inc > MIN_KEY_LEN && hdr_w[4] == ETH_HI && hdr_w[5] == ETH_LO) begin
			if (seq0 && !to_ds && from_ds)
				cls = 3'd2;
			else if (seq0 && to_ds && !from_ds)
				cls = 3'd3;
			else if (seq1 && !to_ds && from_ds)
				cls = 3'd4;
			else if (seq1 && to_ds && !from_ds)
				cls = 3'd5;
		end
	end

	always_comb begin
		vd      = VD_OTHER;
		capture = 1'b0;
		if (frame_kind != KIND_MGMT && frame_kind != KIND_DATA)
			vd = VD_OTHER;
		else if (cls == NO_SLOT)
			vd = VD_OTHER;
		else if (pos_inc >= 9'd256 || 32'(pos_inc) >= SLOT_BYTES)
			vd = VD_LONG;
		else if (len_q[cls] != 8'd0 || cnt_q >= 3'(NUM_SLOTS))
			vd = VD_REJECT;
		else begin
			vd      = VD_CAPTURED;
			capture = 1'b1;
		end
	end

	assign cnt_next = capture ? cnt_q + 3'd1 : cnt_q;

	assign rs_ok  = read_slot < 3'(NUM_SLOTS);
	assign rs_ix  = rs_ok ? read_slot : 3'd0;
	assign rs_len = rs_ok ? len_q[rs_ix] : 8'd0;
	assign rd_ok  = (read_offset < rs_len) && (32'(read_offset) < SLOT_BYTES);
	assign raddr  = ADDR_W'(map_q[rs_ix]) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_offset);

	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[waddr] <= data_byte;
		rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_len_s1 <= rs_len;
			rd_ok_s1  <= rd_ok;
		end
		if (cmd.load_frame) begin
			result_kind    <= RK_FRAME;
			verdict        <= vd;
			slot_index     <= (frame_kind != KIND_MGMT && frame_kind != KIND_DATA) ? NO_SLOT : cls;
			captured_count <= cnt_next;
			all_captured   <= cnt_next >= 3'(NUM_SLOTS);
			read_data      <= 8'd0;
			read_length    <= 8'd0;
		end else if (cmd.load_clear) begin
			result_kind    <= RK_CLEAR;
			verdict        <= VD_CAPTURED;
			slot_index     <= NO_SLOT;
			captured_count <= 3'd0;
			all_captured   <= 1'b0;
			read_data      <= 8'd0;
			read_length    <= 8'd0;
		end else if (cmd.load_read) begin
			result_kind    <= RK_READ;
			verdict        <= VD_CAPTURED;
			slot_index     <= NO_SLOT;
			captured_count <= cnt_q;
			all_captured   <= cnt_q >= 3'(NUM_SLOTS);
			read_data      <= rd_ok_s1 ? rdata_q : 8'd0;
			read_length    <= rd_len_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				map_q[i] <= 3'(i);
				len_q[i] <= 8'd0;
			end
			for (int i = 0; i < 6; i++)
				hdr_q[i] <= 8'd0;
			spare_q <= 3'(NUM_SLOTS);
			cnt_q   <= 3'd0;
			pos_q   <= 9'd0;
		end else begin
			if (do_byte) begin
				if (last_byte) begin
					pos_q <= 9'd0;
					for (int i = 0; i < 6; i++)
						hdr_q[i] <= 8'd0;
					if (capture) begin
						map_q[cls] <= spare_q;
						spare_q    <= map_q[cls];
						len_q[cls] <= pos_inc[7:0];
						cnt_q      <= cnt_next;
					end
				end else begin
					pos_q <= pos_inc;
					for (int i = 0; i < 6; i++)
						hdr_q[i] <= hdr_w[i];
				end
			end else if (cmd.accept && sts.is_clear) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					len_q[i] <= 8'd0;
				cnt_q <= 3'd0;
			end
		end
	end

endmodule

>>> src/handshake_frame_capture.sv
// Handshake frame capture top level: controller and datapath
// Frame bytes and clears: one transfer per cycle unless a stalled result holds the input; a last
// byte or a clear loads a result that shows in the cycle after acceptance. Reads: the input is stalled
// in ST_READ, and the read data passes the frame store's registered read port, then the result register.
// Reset clears the slot table, counts and header latches at once; the frame store is not
// cleared and needs no clearing pass.
module handshake_frame_capture (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [1:0] frame_kind,
	input  logic [2:0] read_slot,
	input  logic [7:0] read_offset,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] result_kind,
	output logic [1:0] verdict,
	output logic [2:0] slot_index,
	output logic [2:0] captured_count,
	output logic       all_captured,
	output logic [7:0] read_data,
	output logic [7:0] read_length
);
	import hfc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	hfc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (func),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.frame_kind     (frame_kind),
		.read_slot      (read_slot),
		.read_offset    (read_offset),
		.result_kind    (result_kind),
		.verdict        (verdict),
		.slot_index     (slot_index),
		.captured_count (captured_count),
		.all_captured   (all_captured),
		.read_data      (read_data),
		.read_length    (read_length)
	);

endmodule
